### src/event_vector_stream_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// event vector stream decoder assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef EVENT_VECTOR_STREAM_DECODER_CORE_ASSERT_SVH
`define EVENT_VECTOR_STREAM_DECODER_CORE_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define EVSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("evsd check failed");

// next-cycle implication
`define EVSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("evsd check failed");

`else

`define EVSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define EVSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/evsd_pkg.sv
// ----------------------------------------------------------------------------
// evsd_pkg
// shared types and constants of the event vector stream decoder
// ----------------------------------------------------------------------------
package evsd_pkg;

    localparam int RAW_W   = 64;
    localparam int MASK_W  = 32;
    localparam int IDX_W   = 5;
    localparam int BASE_W  = 11;
    localparam int X_W     = 12;
    localparam int Y_W     = 11;
    localparam int TH_W    = 28;
    localparam int TL_W    = 6;
    localparam int TIME_W  = 34;
    localparam int TYPE_W  = 4;

    localparam logic [TYPE_W-1:0] TYPE_OFF       = 4'h0;
    localparam logic [TYPE_W-1:0] TYPE_ON        = 4'h1;
    localparam logic [TYPE_W-1:0] TYPE_TIME_HIGH = 4'h8;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // controller to scan unit
    typedef struct packed {
        logic load;
        logic step;
    } t_scan_ctrl;

    // scan unit to controller
    typedef struct packed {
        logic bit_set;
        logic rest_zero;
    } t_scan_stat;

endpackage

### src/event_vector_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// event_vector_stream_decoder_core
// expands 64-bit vector event words into one event per set valid bit
// ----------------------------------------------------------------------------
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+-------------------------------------
//  input    | i_in_valid   | o_in_ready   | i_raw_word
//  output   | o_out_valid  | i_out_ready  | o_pixel_x o_pixel_y o_event_time
//           |              |              | o_polarity o_last_of_word
//
//  time-high, unknown and empty-mask words are taken without a scan.
//  an off/on word with a set mask bit loads the walker and scans up to its
//  highest set bit; the mask walker steps one bit per cycle through one adder,
//  except that output stalls hold it on a set bit; clear bits still advance.
//  results sit in an output register, so a word can be taken while the
//  last result still waits. synchronous active-low reset clears control
//  and the stored time high.
// ----------------------------------------------------------------------------
module event_vector_stream_decoder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [evsd_pkg::RAW_W-1:0]  i_raw_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [evsd_pkg::X_W-1:0]    o_pixel_x,
    output logic [evsd_pkg::Y_W-1:0]    o_pixel_y,
    output logic [evsd_pkg::TIME_W-1:0] o_event_time,
    output logic                        o_polarity,
    output logic                        o_last_of_word
);
    import evsd_pkg::*;

    logic [TYPE_W-1:0] w_type;
    logic              w_accept;
    logic              w_is_vec;
    logic              w_is_th;
    logic              w_start_ok;
    logic              w_out_free;
    logic              w_emit;
    logic [X_W-1:0]    w_pixel_x;
    t_scan_ctrl        w_ctrl;
    t_scan_stat        w_stat;

    logic [TH_W-1:0]   r_time_high;
    logic [TIME_W-1:0] r_stamp;
    logic [Y_W-1:0]    r_row;
    logic              r_pol;

    logic              r_out_valid;
    logic [X_W-1:0]    r_pixel_x;
    logic [Y_W-1:0]    r_pixel_y;
    logic [TIME_W-1:0] r_event_time;
    logic              r_polarity;
    logic              r_last;

    assign w_type   = i_raw_word[63:60];
    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        w_is_vec = 1'b0;
        w_is_th  = 1'b0;
        unique case (w_type) inside
            TYPE_OFF, TYPE_ON: w_is_vec = 1'b1;
            TYPE_TIME_HIGH:    w_is_th  = 1'b1;
            default: ;
        endcase
    end

    assign w_start_ok = w_is_vec && (|i_raw_word[MASK_W-1:0]);
    assign w_out_free = !r_out_valid || i_out_ready;

    evsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_start_ok (w_start_ok),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_emit     (w_emit),
        .o_ctrl     (w_ctrl)
    );

    evsd_scan u_scan (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl),
        .i_mask    (i_raw_word[MASK_W-1:0]),
        .i_base_x  (i_raw_word[53:43]),
        .o_stat    (w_stat),
        .o_pixel_x (w_pixel_x)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_high <= '0;
        end else if (w_accept && w_is_th) begin
            r_time_high <= i_raw_word[59:32];
        end
    end

    // per-word fields, held for the whole scan
    always_ff @(posedge i_clk) begin
        if (w_ctrl.load) begin
            r_stamp <= {r_time_high, i_raw_word[59:54]};
            r_row   <= i_raw_word[42:32];
            r_pol   <= (w_type == TYPE_ON);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_pixel_x    <= w_pixel_x;
            r_pixel_y    <= r_row;
            r_event_time <= r_stamp;
            r_polarity   <= r_pol;
            r_last       <= w_stat.rest_zero;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_x      = r_pixel_x;
    assign o_pixel_y      = r_pixel_y;
    assign o_event_time   = r_event_time;
    assign o_polarity     = r_polarity;
    assign o_last_of_word = r_last;

endmodule

### src/evsd_scan.sv
// ----------------------------------------------------------------------------
// evsd_scan
// valid mask scanner: one mask bit per step, shared column adder
// ----------------------------------------------------------------------------
module evsd_scan (
    input  logic                        i_clk,
    input  evsd_pkg::t_scan_ctrl        i_ctrl,
    input  logic [evsd_pkg::MASK_W-1:0] i_mask,
    input  logic [evsd_pkg::BASE_W-1:0] i_base_x,
    output evsd_pkg::t_scan_stat        o_stat,
    output logic [evsd_pkg::X_W-1:0]    o_pixel_x
);
    import evsd_pkg::*;

    logic [MASK_W-1:0] r_mask, n_mask;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [BASE_W-1:0] r_base_x;

    always_comb begin
        n_mask = r_mask;
        n_idx  = r_idx;
        if (i_ctrl.load) begin
            n_mask = i_mask;
            n_idx  = '0;
        end else if (i_ctrl.step) begin
            n_mask = {1'b0, r_mask[MASK_W-1:1]};
            n_idx  = r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask <= n_mask;
        r_idx  <= n_idx;
        if (i_ctrl.load) begin
            r_base_x <= i_base_x;
        end
    end

    assign o_stat.bit_set   = r_mask[0];
    assign o_stat.rest_zero = ~|r_mask[MASK_W-1:1];

    // base x plus bit index, never wraps in 12 bits
    assign o_pixel_x = X_W'(r_base_x) + X_W'(r_idx);

endmodule

### src/evsd_ctrl.sv
// ----------------------------------------------------------------------------
// evsd_ctrl
// sequencer: takes a word, then, unless a set bit waits for the output slot, walks the mask one bit per cycle
// ----------------------------------------------------------------------------
`include "event_vector_stream_decoder_core_assert.svh"

module evsd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_start_ok,
    input  logic                 i_out_free,
    input  evsd_pkg::t_scan_stat i_stat,
    output logic                 o_in_ready,
    output logic                 o_emit,
    output evsd_pkg::t_scan_ctrl o_ctrl
);
    import evsd_pkg::*;

    t_state r_state, n_state;
    logic   w_step;

    // a clear bit advances freely, a set bit waits for the output slot
    assign w_step = (r_state == ST_SCAN) && (!i_stat.bit_set || i_out_free);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_start_ok) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_step && i_stat.rest_zero) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_emit      = 1'b0;
        o_ctrl.load = 1'b0;
        o_ctrl.step = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_valid && i_start_ok;
            end
            ST_SCAN: begin
                o_ctrl.step = w_step;
                o_emit      = w_step && i_stat.bit_set;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // while scanning, some mask bit is still pending
    `EVSD_ASSERT_IMPLY(a_scan_nonempty, i_clk, i_rst_n, r_state == ST_SCAN, !i_stat.rest_zero || i_stat.bit_set)
    // a result is only produced while the output slot can take it
    `EVSD_ASSERT_IMPLY(a_emit_free, i_clk, i_rst_n, o_emit, i_out_free && r_state == ST_SCAN)
    // a started word always enters the scan
    `EVSD_ASSERT_NEXT(a_load_scan, i_clk, i_rst_n, o_ctrl.load, r_state == ST_SCAN)

endmodule
